>>> hw/rtl/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg: shared definitions for the integer to ASCII formatter
// Conversion and size codes, derived widths and the digit-to-character map.
// ----------------------------------------------------------------------------
package i2a_pkg;

  // Operand width in bits (16 to 64); the input port itself stays 64 bits.
  localparam int VALUE_BITS = 64;

  // Digit counts for each radix at this operand width.
  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int BCD_BITS   = 4 * DEC_DIGITS;

  // The digit shift register holds the widest left-aligned digit string.
  localparam int SR_A    = (BCD_BITS > 3 * OCT_DIGITS) ? BCD_BITS : 3 * OCT_DIGITS;
  localparam int SR_BITS = (SR_A > 4 * HEX_DIGITS) ? SR_A : 4 * HEX_DIGITS;

  // Digit counter and dabble counter width; binary has the most digits.
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  // Conversion selector codes.
  localparam logic [2:0] FUNC_SDEC = 3'd0;
  localparam logic [2:0] FUNC_UDEC = 3'd1;
  localparam logic [2:0] FUNC_OCT  = 3'd2;
  localparam logic [2:0] FUNC_HEXL = 3'd3;
  localparam logic [2:0] FUNC_HEXU = 3'd4;
  localparam logic [2:0] FUNC_BIN  = 3'd5;

  // Size mode codes.
  localparam logic [1:0] SIZE_LONG  = 2'd0;
  localparam logic [1:0] SIZE_SHORT = 2'd1;
  localparam logic [1:0] SIZE_NONE  = 2'd2;

  // ASCII constants.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_UPPER = 8'h41;
  localparam logic [7:0] CHAR_LOWER = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  // Maps one digit value to its ASCII character.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CHAR_UPPER : CHAR_LOWER;
    if (d < 4'd10) begin
      return CHAR_ZERO + {4'b0, d};
    end
    return base + {4'b0, d} - 8'd10;
  endfunction

endpackage

>>> hw/rtl/i2a_bcd.sv
// ----------------------------------------------------------------------------
// i2a_bcd: bit-serial binary to BCD converter
// Shift-and-add-3 conversion, one operand bit per cycle.
// ----------------------------------------------------------------------------
module i2a_bcd (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [i2a_pkg::VALUE_BITS-1:0] bin,
  output logic                           done,
  output logic [i2a_pkg::BCD_BITS-1:0]   bcd
);
  import i2a_pkg::*;

  logic [VALUE_BITS-1:0] shreg;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic [BCD_BITS-1:0]   adj;

  // Each BCD digit of 5 or more gets 3 added before the next shift.
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  // Control: count the operand bits and pulse done after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: shift the operand MSB first into the adjusted BCD word.
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= bin;
      bcd   <= '0;
    end else if (busy) begin
      shreg <= shreg << 1;
      bcd   <= {adj[BCD_BITS-2:0], shreg[VALUE_BITS-1]};
    end
  end

endmodule

>>> hw/rtl/integer_to_ascii_radix_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_formatter: printf-style integer to ASCII text
// Emits the digits of one operand as ASCII characters, MSB digit first.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) takes one word: value, func and
//   size_mode. The output channel (out_valid/out_ready) returns one word per
//   character, char_out, with last set on the final character of the number.
//   Words that produce no text (a size code other than long or short for any
//   conversion but binary, unused func codes) are taken and dropped.
//   Octal, hex and binary: one digit position of the operand per cycle
//   (22, 16 or 64 at 64 bits) while the receiver takes characters, with
//   leading zeros dropped one per cycle even while it stalls.
//   Decimal: the bit-serial BCD converter runs first, then the sign state
//   sends a minus sign for a negative operand, then the BCD digit positions
//   (20 at 64 bits) go out in the same way.
//   A new word is taken only while no item is in progress; the last
//   character may still sit in the output register when it is taken.
//   Reset clears the sequencer and the output valid. When the receiver
//   stalls, the current character holds in the output register and digit
//   generation waits, but leading zeros are still dropped.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] value,
  input  logic [2:0]  func,
  input  logic [1:0]  size_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  char_out,
  output logic        last
);
  import i2a_pkg::*;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DABBLE = 2'd1;
  localparam logic [1:0] ST_SIGN   = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]            state;
  logic [SR_BITS-1:0]    sr;
  logic [CNT_W-1:0]      cnt;
  logic [2:0]            fsel;
  logic                  neg;
  logic                  started;

  logic [VALUE_BITS-1:0] v;
  logic [15:0]           s16;
  logic [VALUE_BITS-1:0] short_u;
  logic [VALUE_BITS-1:0] dec_mag;
  logic                  dec_neg;
  logic                  accept;
  logic                  dab_start;
  logic                  dab_done;
  logic [BCD_BITS-1:0]   bcd;
  logic [3:0]            top;
  logic [3:0]            digit;
  logic                  out_free;
  logic                  skip;
  logic                  emit_char;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Operand views: truncated to VALUE_BITS, short unsigned and decimal magnitude.
  always_comb begin
    v       = value[VALUE_BITS-1:0];
    s16     = v[15:0];
    short_u = VALUE_BITS'(s16);
    dec_neg = 1'b0;
    dec_mag = v;
    if (func == FUNC_SDEC) begin
      if (size_mode == SIZE_SHORT) begin
        dec_neg = s16[15];
        dec_mag = s16[15] ? VALUE_BITS'(16'(-s16)) : short_u;
      end else begin
        dec_neg = v[VALUE_BITS-1];
        dec_mag = v[VALUE_BITS-1] ? -v : v;
      end
    end else if (size_mode == SIZE_SHORT) begin
      dec_mag = short_u;
    end
  end

  assign dab_start = accept && (func == FUNC_SDEC || func == FUNC_UDEC) &&
                     (size_mode == SIZE_LONG || size_mode == SIZE_SHORT);

  i2a_bcd u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (dab_start),
    .bin   (dec_mag),
    .done  (dab_done),
    .bcd   (bcd)
  );

  // Current top digit of the shift register, by radix.
  always_comb begin
    top = sr[SR_BITS-1 -: 4];
    case (fsel)
      FUNC_BIN: digit = {3'b0, top[3]};
      FUNC_OCT: digit = {1'b0, top[3:1]};
      default:  digit = top;
    endcase
    skip = !started && (cnt > CNT_W'(1)) && (digit == 4'd0);
  end

  // A character goes out from the sign state or for a digit that is not skipped.
  assign emit_char = out_free && ((state == ST_SIGN) || (state == ST_EMIT && !skip));

  // Sequencer, digit shift register and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      started   <= 1'b0;
    end else begin
      if (emit_char) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            fsel    <= func;
            neg     <= dec_neg;
            started <= 1'b0;
            if (func == FUNC_BIN) begin
              sr    <= SR_BITS'(v) << (SR_BITS - VALUE_BITS);
              cnt   <= CNT_W'(VALUE_BITS);
              state <= ST_EMIT;
            end else if (size_mode == SIZE_LONG || size_mode == SIZE_SHORT) begin
              case (func)
                FUNC_SDEC, FUNC_UDEC: begin
                  state <= ST_DABBLE;
                end
                FUNC_OCT: begin
                  sr    <= SR_BITS'(dec_mag) << (SR_BITS - 3 * OCT_DIGITS);
                  cnt   <= CNT_W'(OCT_DIGITS);
                  state <= ST_EMIT;
                end
                FUNC_HEXL, FUNC_HEXU: begin
                  sr    <= SR_BITS'(dec_mag) << (SR_BITS - 4 * HEX_DIGITS);
                  cnt   <= CNT_W'(HEX_DIGITS);
                  state <= ST_EMIT;
                end
                default: begin
                  state <= ST_IDLE;
                end
              endcase
            end
          end
        end
        ST_DABBLE: begin
          if (dab_done) begin
            sr    <= SR_BITS'(bcd) << (SR_BITS - BCD_BITS);
            cnt   <= CNT_W'(DEC_DIGITS);
            state <= neg ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            char_out  <= CHAR_MINUS;
            last      <= 1'b0;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Leading zeros are dropped; the final digit always goes out.
          if (skip || out_free) begin
            case (fsel)
              FUNC_BIN: sr <= sr << 1;
              FUNC_OCT: sr <= sr << 3;
              default:  sr <= sr << 4;
            endcase
            cnt <= cnt - 1'b1;
          end
          if (!skip && out_free) begin
            char_out  <= digit_char(digit, fsel == FUNC_HEXU);
            last      <= (cnt == CNT_W'(1));
            started   <= 1'b1;
            if (cnt == CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> dv/tb_integer_to_ascii_radix_formatter.sv
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_radix_formatter: self-checking bench for the formatter
// Feeds operands with every conversion and size code, predicts the ASCII
// text of each word and checks every character and its last flag in order.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_radix_formatter;
  import i2a_pkg::*;

  // Spare codes: words with them give no output, but binary ignores the size code.
  localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  localparam logic [1:0] SIZE_SPARE    = 2'd3;

  // Quiet cycles allowed before the run is declared hung, and the settle time
  // after the text queue empties.
  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } glyph_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] value;
  logic [2:0]  func;
  logic [1:0]  size_mode;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  char_out;
  logic        last;

  // Characters still owed by the block, oldest first.
  glyph_t pending_text[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_left;
  int text_len;
  int mismatch_count;
  int chars_checked;
  int quiet_cycles;
  int words_sent;
  int words_per_func[8];
  glyph_t want;

  integer_to_ascii_radix_formatter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .func      (func),
    .size_mode (size_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_out  (char_out),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Works out the text of one word and queues it; returns its length.
  function automatic int format_number(input logic [63:0] raw, input logic [2:0] fn,
                                       input logic [1:0] mode);
    logic [63:0] mask;
    logic [63:0] v;
    logic [63:0] mag;
    logic [63:0] radix;
    logic [63:0] d;
    logic [15:0] s;
    logic [7:0]  alpha;
    logic [7:0]  rev[64];
    logic [7:0]  text[$];
    logic        neg;
    logic        emit;
    int          n;
    mask  = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
    v     = raw & mask;
    neg   = 1'b0;
    emit  = 1'b1;
    mag   = v;
    radix = 64'd10;
    alpha = CHAR_LOWER;
    if (fn > FUNC_BIN) begin
      emit = 1'b0;
    end else if (fn == FUNC_BIN) begin
      radix = 64'd2;
    end else if (mode != SIZE_LONG && mode != SIZE_SHORT) begin
      emit = 1'b0;
    end else if (fn == FUNC_SDEC) begin
      // The magnitude is unsigned, so the most negative value needs no care.
      if (mode == SIZE_SHORT) begin
        s   = v[15:0];
        neg = s[15];
        mag = neg ? {48'd0, 16'd0 - s} : {48'd0, s};
      end else begin
        neg = v[VALUE_BITS-1];
        mag = neg ? ((~v + 64'd1) & mask) : v;
      end
    end else begin
      if (mode == SIZE_SHORT) begin
        mag = {48'd0, v[15:0]};
      end
      case (fn)
        FUNC_OCT:  radix = 64'd8;
        FUNC_HEXL: radix = 64'd16;
        FUNC_HEXU: begin
          radix = 64'd16;
          alpha = CHAR_UPPER;
        end
        default:   radix = 64'd10;
      endcase
    end
    if (emit) begin
      if (neg) begin
        text.push_back(CHAR_MINUS);
      end
      // Digits come out least significant first; zero still gives one.
      n = 0;
      do begin
        d = mag % radix;
        rev[n] = (d < 64'd10) ? CHAR_ZERO + d[7:0] : alpha + d[7:0] - 8'd10;
        n++;
        mag = mag / radix;
      end while (mag != 64'd0 && n < 64);
      for (int i = n - 1; i >= 0; i--) begin
        text.push_back(rev[i]);
      end
    end
    for (int i = 0; i < text.size(); i++) begin
      pending_text.push_back('{ch: text[i], is_last: (i == text.size() - 1)});
    end
    return text.size();
  endfunction

  // Picks an operand, leaning toward sign edges, small numbers and single bits.
  function automatic logic [63:0] pick_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(5))
      0, 1: pick_value = r;
      2:    pick_value = 64'($urandom_range(999));
      3:    pick_value = r >> $urandom_range(63);
      4:    pick_value = $urandom_range(1) ? (64'd1 << $urandom_range(63))
                                           : 64'd0 - 64'($urandom_range(1, 1000));
      default: begin
        case ($urandom_range(3))
          0:       pick_value = {r[63:16], 16'h0000};
          1:       pick_value = {r[63:16], 16'h7fff};
          2:       pick_value = {r[63:16], 16'h8000};
          default: pick_value = {r[63:16], 16'hffff};
        endcase
      end
    endcase
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Offers one word, with random idle cycles ahead of it, and predicts its
  // text once the block has taken it.
  task automatic send_word(input logic [63:0] val, input logic [2:0] fn,
                           input logic [1:0] mode);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    value     <= val;
    func      <= fn;
    size_mode <= mode;
    do @(posedge clk); while (!in_ready);
    text_len = format_number(val, fn, mode);
    words_sent++;
    words_per_func[fn]++;
  endtask

  // Stops offering and waits until every owed character has been taken.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    // Signed decimal: zero, the sign extremes and minus one.
    send_word(64'd0, FUNC_SDEC, SIZE_LONG);
    send_word(64'h8000_0000_0000_0000, FUNC_SDEC, SIZE_LONG);
    send_word(64'h7fff_ffff_ffff_ffff, FUNC_SDEC, SIZE_LONG);
    send_word(64'hffff_ffff_ffff_ffff, FUNC_SDEC, SIZE_LONG);
    // Widest text of each radix.
    send_word(64'hffff_ffff_ffff_ffff, FUNC_UDEC, SIZE_LONG);
    send_word(64'hffff_ffff_ffff_ffff, FUNC_OCT, SIZE_LONG);
    send_word(64'hdead_beef_cafe_f00d, FUNC_HEXL, SIZE_LONG);
    send_word(64'hdead_beef_cafe_f00d, FUNC_HEXU, SIZE_LONG);
    send_word(64'hffff_ffff_ffff_ffff, FUNC_BIN, SIZE_LONG);
    send_word(64'd0, FUNC_BIN, SIZE_LONG);
    // Short mode truncates, and sign-extends for signed decimal.
    send_word(64'h1234_5678_9abc_8000, FUNC_SDEC, SIZE_SHORT);
    send_word(64'hffff_ffff_ffff_7fff, FUNC_SDEC, SIZE_SHORT);
    send_word(64'h0000_0000_0000_ffff, FUNC_SDEC, SIZE_SHORT);
    send_word(64'h0000_0001_2345_ffff, FUNC_UDEC, SIZE_SHORT);
    send_word(64'hffff_0000_0000_ffff, FUNC_OCT, SIZE_SHORT);
    send_word(64'h5555_aaaa_5555_abcd, FUNC_HEXL, SIZE_SHORT);
    send_word(64'hffff_ffff_ffff_0000, FUNC_HEXU, SIZE_SHORT);
    // Binary ignores the size code, short, none and spare alike.
    send_word(64'haaaa_5555_0000_ffff, FUNC_BIN, SIZE_SHORT);
    send_word(64'h0000_0000_0000_0005, FUNC_BIN, SIZE_SPARE);
    send_word(64'h8000_0000_0000_0001, FUNC_BIN, SIZE_NONE);
    // Words that give no text.
    send_word(64'd123, FUNC_SDEC, SIZE_NONE);
    send_word(64'hffff, FUNC_HEXL, SIZE_NONE);
    send_word(64'd456, FUNC_UDEC, SIZE_SPARE);
    send_word(64'hffff_ffff_ffff_ffff, FUNC_SPARE_LO, SIZE_LONG);
    send_word(64'h1, FUNC_SPARE_HI, SIZE_SHORT);
  endtask

  // Random words under one idle setting until n of them have given text.
  task automatic test_random_words(input int tx_pct, input int rx_pct, input int n);
    int          produced;
    logic [2:0]  fn;
    logic [1:0]  mode;
    produced    = 0;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (produced < n) begin
      fn   = ($urandom_range(99) < 6) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      mode = ($urandom_range(99) < 10) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1));
      send_word(pick_value(), fn, mode);
      if (text_len > 0) begin
        produced++;
      end
    end
  endtask

  // The receiver holds off while the sender keeps offering, so the block
  // fills up and stops taking words.
  task automatic test_receiver_holdoff();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_left   = HOLD_CYCLES;
    for (int k = 0; k < 6; k++) begin
      send_word(pick_value(), 3'($urandom_range(5)), SIZE_LONG);
    end
    pause_until_drained();
  endtask

  // The sender waits for the block to go quiet between two bursts.
  task automatic test_pause_until_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int k = 0; k < 5; k++) begin
      send_word(pick_value(), 3'($urandom_range(5)), 2'($urandom_range(1)));
    end
    pause_until_drained();
    for (int k = 0; k < 5; k++) begin
      send_word(pick_value(), 3'($urandom_range(5)), 2'($urandom_range(1)));
    end
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Each character taken is checked against the oldest owed one.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      chars_checked++;
      if (pending_text.size() == 0) begin
        note_mismatch($sformatf("unexpected char %h last %b", char_out, last));
      end else begin
        want = pending_text.pop_front();
        if (char_out !== want.ch || last !== want.is_last) begin
          note_mismatch($sformatf("char expected %h (%c) last %b, got %h (%c) last %b",
                                  want.ch, want.ch, want.is_last, char_out, char_out, last));
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid === 1'b1 && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d chars owed",
                 QUIET_LIMIT, pending_text.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    hold_left      = 0;
    text_len       = 0;
    mismatch_count = 0;
    chars_checked  = 0;
    quiet_cycles   = 0;
    words_sent     = 0;
    foreach (words_per_func[i]) words_per_func[i] = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    value     <= 64'd0;
    func      <= FUNC_SDEC;
    size_mode <= SIZE_LONG;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 28;
    rx_idle_pct = 71;
    test_directed_cases();
    test_random_words(28, 71, 33);
    test_random_words(71, 28, 33);
    test_random_words(0, 0, 33);
    test_receiver_holdoff();
    test_pause_until_drained();
    pause_until_drained();

    if (pending_text.size() != 0) begin
      note_mismatch($sformatf("%0d chars never arrived", pending_text.size()));
    end
    $display("Run covered %0d words (sdec %0d udec %0d oct %0d hexl %0d hexu %0d bin %0d",
             words_sent, words_per_func[0], words_per_func[1], words_per_func[2],
             words_per_func[3], words_per_func[4], words_per_func[5]);
    $display("  spare %0d) and checked %0d characters, %0d mismatches.",
             words_per_func[6] + words_per_func[7], chars_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> integer_to_ascii_radix_formatter.f
hw/rtl/i2a_pkg.sv
hw/rtl/i2a_bcd.sv
hw/rtl/integer_to_ascii_radix_formatter.sv
dv/tb_integer_to_ascii_radix_formatter.sv
